### rtl/core/multi_policy_rate_limiter_assert.svh
// Assertion macros shared by the rate limiter modules.
`ifndef MULTI_POLICY_RATE_LIMITER_ASSERT_SVH
`define MULTI_POLICY_RATE_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rate limiter check failed");

// The consequent must hold in the cycle after the antecedent.
`define MPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rate limiter check failed");

`endif

### rtl/core/mpr_pkg.sv
// Types, constants and codes shared by the rate limiter modules.
package mpr_pkg;

   localparam int HISTORY_DEPTH_DEF = 64;

   localparam int BYTES_W  = 16;
   localparam int TIME_W   = 32;
   localparam int RATE_W   = 24;
   localparam int TOKEN_W  = 28;
   localparam int POLICY_W = 2;
   localparam int CSR_INDEX_W = 2;

   // Window length in milliseconds; an entry of exactly this age still counts.
   localparam logic [TIME_W-1:0] WINDOW_MS = 32'd1000;

   // Policy codes.
   localparam logic [POLICY_W-1:0] POL_TOKEN  = 2'd0;
   localparam logic [POLICY_W-1:0] POL_LEAKY  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WINDOW = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_POLICY   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 2'd2;

   // Item kinds.
   localparam logic MODE_OFFER = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd1024;
   localparam logic [TOKEN_W-1:0] TOKEN_RESET = 28'd20480;

   // Division by ten as a multiply by ceil(2^31/10) and a shift; exact below 2^28.
   localparam logic [TOKEN_W-1:0] DIV10_MULT  = 28'd214748365;
   localparam int                 DIV10_SHIFT = 31;

   typedef struct packed {
      logic               mode;
      logic [BYTES_W-1:0] packet_bytes;
      logic [TIME_W-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic [BYTES_W-1:0] passed_bytes;
      logic [BYTES_W-1:0] dropped_bytes;
      logic               packet_dropped;
      logic               burst;
      logic [RATE_W-1:0]  quota_bytes;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT,
      ST_DIVA,
      ST_UPDATE,
      ST_DIVB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic pop;
      logic div_go;
      logic update;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic new_window;
      logic evict_stop;
   } status_type;

endpackage

### rtl/core/mpr_ctrl.sv
// Rate limiter sequencer: window eviction, division, update and output load per word.
`include "multi_policy_rate_limiter_assert.svh"

module mpr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  mpr_pkg::status_type status,
   output mpr_pkg::cmd_type    cmd
);

   mpr_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         mpr_pkg::ST_IDLE: begin
            // Nothing is taken while reset is held.
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = status.new_window ? mpr_pkg::ST_EVICT : mpr_pkg::ST_DIVA;
            end
         end
         mpr_pkg::ST_EVICT: begin
            if (status.evict_stop) begin
               state_in = mpr_pkg::ST_DIVA;
            end else begin
               cmd.pop = 1'b1;
            end
         end
         mpr_pkg::ST_DIVA: begin
            cmd.div_go = 1'b1;
            state_in   = mpr_pkg::ST_UPDATE;
         end
         mpr_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = mpr_pkg::ST_DIVB;
         end
         mpr_pkg::ST_DIVB: begin
            cmd.div_go = 1'b1;
            state_in   = mpr_pkg::ST_DONE;
         end
         mpr_pkg::ST_DONE: begin
            // The output register is free if empty or being taken this cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = mpr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   `MPR_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.out_load, !(rsp_valid_ff && rsp_stall))
   `MPR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, state_ff != mpr_pkg::ST_IDLE)
   `MPR_ASSERT_SAME(a_stall_when_busy, clock, reset, state_ff != mpr_pkg::ST_IDLE, req_stall)

endmodule

### rtl/core/mpr_dpath.sv
// Datapath of the rate limiter: registers, token arithmetic, history memory and result.
`include "multi_policy_rate_limiter_assert.svh"

module mpr_dpath #(
   parameter int HISTORY_DEPTH = mpr_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mpr_pkg::cmd_type                     cmd,
   output mpr_pkg::status_type                  status,
   input  mpr_pkg::req_type                     req_word,
   output mpr_pkg::rsp_type                     rsp_word,
   input  logic                                 csr_we,
   input  logic [mpr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mpr_pkg::RATE_W-1:0]           csr_wdata
);

   localparam int PTR_W   = $clog2(HISTORY_DEPTH);
   localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int ENTRY_W = mpr_pkg::TIME_W + mpr_pkg::BYTES_W;
   localparam int PROD_W  = 2 * mpr_pkg::TOKEN_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);
   localparam logic [PTR_W:0]   SLOT_WRAP = (PTR_W + 1)'(HISTORY_DEPTH);

   // Configuration and policy state.
   logic [mpr_pkg::POLICY_W-1:0] policy_ff, policy_in;
   logic [mpr_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic [mpr_pkg::TOKEN_W-1:0]  cap10_ff, cap10_in;
   logic [mpr_pkg::TOKEN_W-1:0]  token_ff, token_in;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [mpr_pkg::RATE_W-1:0]   sum_ff, sum_in;

   // Per-word working registers.
   mpr_pkg::req_type             item_ff;
   logic [mpr_pkg::RATE_W-1:0]   div_q_ff, div_q_in;
   logic [mpr_pkg::BYTES_W-1:0]  passed_ff, passed_in;
   logic                         burst_ff, burst_in;
   mpr_pkg::rsp_type             rsp_word_ff, rsp_word_in;

   // History memory.
   logic [ENTRY_W-1:0]           hist_mem_ff [HISTORY_DEPTH];
   logic [ENTRY_W-1:0]           rd_data_ff;
   logic [PTR_W-1:0]             rd_addr, wr_addr;
   logic                         mem_we;

   logic [PTR_W-1:0]             head_inc;
   logic [PTR_W:0]               slot_wide;
   logic [mpr_pkg::TIME_W-1:0]   age;
   logic                         expired;
   logic [mpr_pkg::RATE_W-1:0]   left;
   logic [mpr_pkg::RATE_W-1:0]   size_wide;
   logic [mpr_pkg::BYTES_W-1:0]  push_bytes;
   logic                         push_want;
   logic                         push_ok;
   logic [mpr_pkg::TOKEN_W-1:0]  need;
   logic                         fits;
   logic [mpr_pkg::TOKEN_W-1:0]  tick_sum;
   logic [mpr_pkg::TOKEN_W-1:0]  tick_tok;
   logic [mpr_pkg::RATE_W-1:0]   csr_val;
   logic [mpr_pkg::TOKEN_W-1:0]  csr_val10;
   logic [mpr_pkg::TOKEN_W-1:0]  div_op;
   logic [PROD_W-1:0]            div_prod;
   logic [mpr_pkg::RATE_W-1:0]   quota;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= mpr_pkg::POL_TOKEN;
         rate_ff   <= mpr_pkg::RATE_RESET;
         cap10_ff  <= mpr_pkg::TOKEN_RESET;
         token_ff  <= mpr_pkg::TOKEN_RESET;
         head_ff   <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
      end else begin
         policy_ff <= policy_in;
         rate_ff   <= rate_in;
         cap10_ff  <= cap10_in;
         token_ff  <= token_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_word;
      end
      div_q_ff    <= div_q_in;
      passed_ff   <= passed_in;
      burst_ff    <= burst_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem_ff[wr_addr] <= {item_ff.now_ms, push_bytes};
      end
      rd_data_ff <= hist_mem_ff[rd_addr];
   end

   // Eviction looks at the oldest entry; popping reads ahead at the next one.
   assign head_inc = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
   assign rd_addr  = cmd.pop ? head_inc : head_ff;
   assign age      = item_ff.now_ms - rd_data_ff[ENTRY_W-1 -: mpr_pkg::TIME_W];
   assign expired  = age > mpr_pkg::WINDOW_MS;

   assign status.evict_stop = (count_ff == '0) || !expired;
   assign status.new_window = (policy_ff == mpr_pkg::POL_WINDOW) &&
                              (req_word.mode == mpr_pkg::MODE_OFFER);

   assign slot_wide = (PTR_W + 1)'(head_ff) + (PTR_W + 1)'(count_ff);
   assign wr_addr   = (slot_wide >= SLOT_WRAP) ? PTR_W'(slot_wide - SLOT_WRAP)
                                               : PTR_W'(slot_wide);

   assign left       = (sum_ff >= rate_ff) ? '0 : rate_ff - sum_ff;
   assign size_wide  = mpr_pkg::RATE_W'(item_ff.packet_bytes);
   assign push_want  = (left != '0) || (item_ff.packet_bytes == '0);
   assign push_bytes = (left >= size_wide) ? item_ff.packet_bytes
                                           : left[mpr_pkg::BYTES_W-1:0];
   assign push_ok    = push_want && (count_ff != CNT_FULL);

   assign need     = (mpr_pkg::TOKEN_W'(item_ff.packet_bytes) << 3) +
                     (mpr_pkg::TOKEN_W'(item_ff.packet_bytes) << 1);
   assign fits     = token_ff >= need;
   assign tick_sum = token_ff + mpr_pkg::TOKEN_W'(rate_ff);
   assign tick_tok = (tick_sum > cap10_ff) ? cap10_ff : tick_sum;

   assign csr_val   = (csr_wdata == '0) ? mpr_pkg::RATE_W'(1) : csr_wdata;
   assign csr_val10 = (mpr_pkg::TOKEN_W'(csr_val) << 3) + (mpr_pkg::TOKEN_W'(csr_val) << 1);

   // Shared divide-by-ten: rate under the leaky bucket, tokens otherwise.
   assign div_op   = (policy_ff == mpr_pkg::POL_LEAKY) ? mpr_pkg::TOKEN_W'(rate_ff) : token_ff;
   assign div_prod = PROD_W'(div_op) * PROD_W'(mpr_pkg::DIV10_MULT);
   assign div_q_in = cmd.div_go ? div_prod[mpr_pkg::DIV10_SHIFT +: mpr_pkg::RATE_W] : div_q_ff;

   always_comb begin
      policy_in = policy_ff;
      rate_in   = rate_ff;
      cap10_in  = cap10_ff;
      token_in  = token_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      passed_in = passed_ff;
      burst_in  = burst_ff;
      mem_we    = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            mpr_pkg::CSR_POLICY: begin
               policy_in = csr_wdata[mpr_pkg::POLICY_W-1:0];
               token_in  = cap10_ff;
            end
            mpr_pkg::CSR_RATE: begin
               rate_in = csr_val;
            end
            mpr_pkg::CSR_CAPACITY: begin
               cap10_in = csr_val10;
               if (token_ff > csr_val10) begin
                  token_in = csr_val10;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.pop) begin
         head_in  = head_inc;
         count_in = count_ff - CNT_W'(1);
         sum_in   = sum_ff - mpr_pkg::RATE_W'(rd_data_ff[mpr_pkg::BYTES_W-1:0]);
      end

      if (cmd.update) begin
         passed_in = '0;
         burst_in  = 1'b0;
         if (item_ff.mode == mpr_pkg::MODE_TICK) begin
            if (policy_ff == mpr_pkg::POL_TOKEN) begin
               token_in = tick_tok;
            end
         end else begin
            case (policy_ff)
               mpr_pkg::POL_TOKEN: begin
                  if (fits) begin
                     token_in  = token_ff - need;
                     passed_in = item_ff.packet_bytes;
                     burst_in  = size_wide > (rate_ff >> 1);
                  end else begin
                     // Whole bytes of the tokens pass; the bucket empties if any did.
                     passed_in = div_q_ff[mpr_pkg::BYTES_W-1:0];
                     if (div_q_ff != '0) begin
                        token_in = '0;
                     end
                  end
               end
               mpr_pkg::POL_LEAKY: begin
                  passed_in = (div_q_ff > size_wide) ? item_ff.packet_bytes
                                                     : div_q_ff[mpr_pkg::BYTES_W-1:0];
               end
               mpr_pkg::POL_WINDOW: begin
                  if (push_ok) begin
                     mem_we    = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     sum_in    = sum_ff + mpr_pkg::RATE_W'(push_bytes);
                     passed_in = push_bytes;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      case (policy_ff)
         mpr_pkg::POL_TOKEN:  quota = div_q_ff;
         mpr_pkg::POL_LEAKY:  quota = div_q_ff;
         mpr_pkg::POL_WINDOW: quota = left;
         default:             quota = '0;
      endcase
   end

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (cmd.out_load) begin
         rsp_word_in.passed_bytes   = passed_ff;
         rsp_word_in.burst          = burst_ff;
         rsp_word_in.quota_bytes    = quota;
         if (item_ff.mode == mpr_pkg::MODE_TICK) begin
            rsp_word_in.dropped_bytes  = '0;
            rsp_word_in.packet_dropped = 1'b0;
         end else begin
            rsp_word_in.dropped_bytes  = item_ff.packet_bytes - passed_ff;
            rsp_word_in.packet_dropped = passed_ff < item_ff.packet_bytes;
         end
      end
   end

   assign rsp_word = rsp_word_ff;

   `MPR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL)
   `MPR_ASSERT_SAME(a_empty_sum, clock, reset, count_ff == '0, sum_ff == '0)
   `MPR_ASSERT_SAME(a_token_cap, clock, reset, 1'b1, token_ff <= cap10_ff)

endmodule

### rtl/core/multi_policy_rate_limiter.sv
// Multi-policy rate limiter: token bucket, leaky bucket or sliding window on each offered
// packet, with 100 ms refill ticks; one result word per input word. A word is taken only
// while the sequencer is idle; each passes capture, divide, update, divide and the load of
// the output register before the next is accepted, since the single divide-by-ten
// multiplier is used once before and once after the state update. The load waits while the
// output register still holds a stalled result. A sliding-window offer first evicts expired
// history entries, the history memory yielding one entry per cycle. A finished result waits
// in the output register while the next word is accepted. Tokens are kept in tenths of a byte.
module multi_policy_rate_limiter #(
   parameter int HISTORY_DEPTH = mpr_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mpr_pkg::req_type                req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mpr_pkg::rsp_type                rsp_word,
   input  logic                            csr_we,
   input  logic [mpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mpr_pkg::RATE_W-1:0]      csr_wdata
);

   mpr_pkg::cmd_type    cmd;
   mpr_pkg::status_type status;

   mpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mpr_dpath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-policy rate limiter, with its own predictor.
module tb_top;

   localparam int HISTORY = mpr_pkg::HISTORY_DEPTH_DEF;
   localparam logic [mpr_pkg::POLICY_W-1:0] POL_UNUSED = 2'd3;
   localparam logic [mpr_pkg::RATE_W-1:0] CAPACITY_RESET = 24'd2048;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mpr_pkg::req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mpr_pkg::rsp_type rsp_word;
   logic csr_we = 1'b0;
   logic [mpr_pkg::CSR_INDEX_W-1:0] csr_index = mpr_pkg::CSR_POLICY;
   logic [mpr_pkg::RATE_W-1:0] csr_wdata = '0;

   multi_policy_rate_limiter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predicted limiter state and configuration.
   logic [mpr_pkg::POLICY_W-1:0] lim_policy = mpr_pkg::POL_TOKEN;
   logic [mpr_pkg::RATE_W-1:0] lim_rate = mpr_pkg::RATE_RESET;
   logic [mpr_pkg::RATE_W-1:0] lim_capacity = CAPACITY_RESET;
   logic [31:0] lim_tokens = 32'(mpr_pkg::TOKEN_RESET);
   logic [mpr_pkg::TIME_W-1:0] hist_time [HISTORY];
   logic [mpr_pkg::BYTES_W-1:0] hist_bytes [HISTORY];
   int unsigned hist_head = 0;
   int unsigned hist_count = 0;
   logic [31:0] hist_sum = '0;

   mpr_pkg::rsp_type pending_verdicts [$];
   logic [mpr_pkg::TIME_W-1:0] now_cursor = '0;
   bit send_gaps = 1'b1;
   bit recv_gaps = 1'b1;
   int errors = 0;
   int offers_seen = 0;
   int ticks_seen = 0;
   int bursts_seen = 0;
   int history_full_drops = 0;
   int evictions = 0;
   int results_checked = 0;
   int quiet_cycles = 0;

   function automatic mpr_pkg::rsp_type limiter_verdict(input mpr_pkg::req_type w);
      mpr_pkg::rsp_type r;
      logic [31:0] size;
      logic [31:0] passed;
      logic [31:0] left;
      logic [31:0] age;
      logic [31:0] cap_tenths;
      logic [31:0] share;
      logic burst;
      size = 32'(w.packet_bytes);
      passed = '0;
      burst = 1'b0;
      cap_tenths = 32'(lim_capacity) * 10;
      if (w.mode == mpr_pkg::MODE_TICK) begin
         ticks_seen++;
         if (lim_policy == mpr_pkg::POL_TOKEN)
            lim_tokens = (lim_tokens + lim_rate > cap_tenths) ? cap_tenths
                                                               : lim_tokens + lim_rate;
      end else begin
         offers_seen++;
         case (lim_policy)
            mpr_pkg::POL_TOKEN: begin
               if (lim_tokens >= size * 10) begin
                  lim_tokens -= size * 10;
                  passed = size;
                  burst = size > 32'(lim_rate >> 1);
               end else begin
                  passed = lim_tokens / 10;
                  if (passed != 0)
                     lim_tokens = '0;
               end
            end
            mpr_pkg::POL_LEAKY: begin
               passed = lim_rate / 10;
               if (passed > size)
                  passed = size;
            end
            mpr_pkg::POL_WINDOW: begin
               // Oldest entries go first; an entry aged exactly the window still counts.
               while (hist_count > 0) begin
                  age = w.now_ms - hist_time[hist_head];
                  if (age <= mpr_pkg::WINDOW_MS)
                     break;
                  hist_sum -= hist_bytes[hist_head];
                  hist_head = (hist_head + 1) % HISTORY;
                  hist_count--;
                  evictions++;
               end
               left = (hist_sum >= lim_rate) ? '0 : lim_rate - hist_sum;
               // A zero-byte packet always fits whole and is still recorded unless the history is full.
               if (left >= size || left != 0) begin
                  share = (left >= size) ? size : left;
                  if (hist_count < HISTORY) begin
                     hist_time[(hist_head + hist_count) % HISTORY] = w.now_ms;
                     hist_bytes[(hist_head + hist_count) % HISTORY] =
                        share[mpr_pkg::BYTES_W-1:0];
                     hist_count++;
                     hist_sum += share;
                     passed = share;
                  end else begin
                     history_full_drops++;
                  end
               end
            end
            default: passed = '0;
         endcase
      end
      bursts_seen += burst;
      r.passed_bytes = passed[mpr_pkg::BYTES_W-1:0];
      r.dropped_bytes = (w.mode == mpr_pkg::MODE_TICK) ? '0 : 16'(size - passed);
      r.packet_dropped = (w.mode == mpr_pkg::MODE_OFFER) && (passed < size);
      r.burst = burst;
      case (lim_policy)
         mpr_pkg::POL_TOKEN: r.quota_bytes = 24'(lim_tokens / 10);
         mpr_pkg::POL_LEAKY: r.quota_bytes = 24'(lim_rate / 10);
         mpr_pkg::POL_WINDOW:
            r.quota_bytes = (hist_sum >= lim_rate) ? '0 : 24'(lim_rate - hist_sum);
         default: r.quota_bytes = '0;
      endcase
      return r;
   endfunction

   task automatic send_word(input logic mode, input logic [mpr_pkg::BYTES_W-1:0] size,
                            input logic [mpr_pkg::TIME_W-1:0] stamp);
      mpr_pkg::req_type w;
      int gap;
      w.mode = mode;
      w.packet_bytes = size;
      w.now_ms = stamp;
      gap = send_gaps ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      pending_verdicts.push_back(limiter_verdict(w));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [mpr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mpr_pkg::RATE_W-1:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mpr_pkg::CSR_POLICY: begin
            lim_policy = value[mpr_pkg::POLICY_W-1:0];
            lim_tokens = 32'(lim_capacity) * 10;
         end
         mpr_pkg::CSR_RATE: lim_rate = (value == '0) ? 24'd1 : value;
         mpr_pkg::CSR_CAPACITY: begin
            lim_capacity = (value == '0) ? 24'd1 : value;
            if (lim_tokens > 32'(lim_capacity) * 10)
               lim_tokens = 32'(lim_capacity) * 10;
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_results
      mpr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result word %h arrived with nothing expected", $time, rsp_word);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("passed_bytes", want.passed_bytes, rsp_word.passed_bytes);
            check_field("dropped_bytes", want.dropped_bytes, rsp_word.dropped_bytes);
            check_field("packet_dropped", want.packet_dropped, rsp_word.packet_dropped);
            check_field("burst", want.burst, rsp_word.burst);
            check_field("quota_bytes", want.quota_bytes, rsp_word.quota_bytes);
            results_checked++;
         end
      end
   end

   // The receiver draws a fresh stall length after every word it takes.
   always @(posedge clock) begin : receiver_pacing
      static int stall_left = 0;
      if (!reset && rsp_valid && !rsp_stall)
         stall_left = recv_gaps ? $urandom_range(0, 19) : 0;
      else if (stall_left > 0)
         stall_left--;
      rsp_stall <= (stall_left != 0);
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic test_token_bucket();
      csr_write(mpr_pkg::CSR_POLICY, mpr_pkg::POL_TOKEN);
      send_word(mpr_pkg::MODE_OFFER, 16'd0, now_cursor);
      // A packet larger than the bucket passes the whole-byte tokens and empties it.
      send_word(mpr_pkg::MODE_OFFER, 16'hFFFF, now_cursor);
      send_word(mpr_pkg::MODE_OFFER, 16'd1, now_cursor);
      send_word(mpr_pkg::MODE_TICK, 16'hFFFF, now_cursor);
      send_word(mpr_pkg::MODE_OFFER, 16'd102, now_cursor);
      csr_write(mpr_pkg::CSR_POLICY, mpr_pkg::POL_TOKEN);
      send_word(mpr_pkg::MODE_OFFER, 16'd600, now_cursor);
      send_word(mpr_pkg::MODE_OFFER, 16'd512, now_cursor);
      csr_write(mpr_pkg::CSR_RATE, 24'hFFFFFF);
      send_word(mpr_pkg::MODE_TICK, 16'd0, now_cursor);
   endtask

   task automatic test_leaky_bucket();
      csr_write(mpr_pkg::CSR_POLICY, mpr_pkg::POL_LEAKY);
      csr_write(mpr_pkg::CSR_RATE, 24'd0);
      send_word(mpr_pkg::MODE_OFFER, 16'd50, now_cursor);
      send_word(mpr_pkg::MODE_TICK, 16'd7, now_cursor);
      csr_write(mpr_pkg::CSR_RATE, 24'hFFFFFF);
      send_word(mpr_pkg::MODE_OFFER, 16'hFFFF, now_cursor);
      csr_write(mpr_pkg::CSR_RATE, 24'd1000);
      send_word(mpr_pkg::MODE_OFFER, 16'd150, now_cursor);
   endtask

   task automatic test_sliding_window();
      logic [mpr_pkg::TIME_W-1:0] t0;
      t0 = now_cursor;
      csr_write(mpr_pkg::CSR_POLICY, mpr_pkg::POL_WINDOW);
      csr_write(mpr_pkg::CSR_RATE, 24'd100);
      send_word(mpr_pkg::MODE_OFFER, 16'd60, t0);
      send_word(mpr_pkg::MODE_OFFER, 16'd60, t0 + 10);
      send_word(mpr_pkg::MODE_OFFER, 16'd0, t0 + 20);
      send_word(mpr_pkg::MODE_TICK, 16'd0, t0 + 30);
      send_word(mpr_pkg::MODE_OFFER, 16'd10, t0 + mpr_pkg::WINDOW_MS);
      send_word(mpr_pkg::MODE_OFFER, 16'd10, t0 + mpr_pkg::WINDOW_MS + 1);
      // Ages are taken modulo 2^32 across the wrap of the millisecond counter.
      send_word(mpr_pkg::MODE_OFFER, 16'd20, 32'hFFFF_FF00);
      send_word(mpr_pkg::MODE_OFFER, 16'd20, 32'h0000_0100);
      now_cursor = 32'h0000_0100;
   endtask

   task automatic test_unused_policy();
      csr_write(mpr_pkg::CSR_POLICY, POL_UNUSED);
      send_word(mpr_pkg::MODE_OFFER, 16'd100, now_cursor);
      send_word(mpr_pkg::MODE_TICK, 16'd0, now_cursor);
   endtask

   task automatic test_capacity_clamp();
      csr_write(mpr_pkg::CSR_POLICY, mpr_pkg::POL_TOKEN);
      csr_write(mpr_pkg::CSR_RATE, 24'd5);
      csr_write(mpr_pkg::CSR_CAPACITY, 24'd0);
      send_word(mpr_pkg::MODE_OFFER, 16'd2, now_cursor);
      send_word(mpr_pkg::MODE_TICK, 16'd0, now_cursor);
      send_word(mpr_pkg::MODE_OFFER, 16'd1, now_cursor);
      csr_write(mpr_pkg::CSR_CAPACITY, 24'hFFFFFF);
      csr_write(mpr_pkg::CSR_POLICY, mpr_pkg::POL_TOKEN);
      send_word(mpr_pkg::MODE_OFFER, 16'hFFFF, now_cursor);
   endtask

   task automatic test_full_history();
      csr_write(mpr_pkg::CSR_POLICY, mpr_pkg::POL_WINDOW);
      csr_write(mpr_pkg::CSR_RATE, 24'hFFFFFF);
      now_cursor += 5000;
      for (int i = 0; i < HISTORY + 2; i++)
         send_word(mpr_pkg::MODE_OFFER, 16'($urandom_range(0, 255)), now_cursor);
      // One step past the window evicts the whole history in a single offer.
      now_cursor += mpr_pkg::WINDOW_MS + 1;
      send_word(mpr_pkg::MODE_OFFER, 16'($urandom_range(0, 255)), now_cursor);
   endtask

   function automatic logic [mpr_pkg::RATE_W-1:0] pick_register_value();
      case ($urandom_range(0, 9))
         0: return 24'd1;
         1: return 24'hFFFFFF;
         2: return 24'($urandom);
         default: return 24'($urandom_range(20, 20000));
      endcase
   endfunction

   task automatic test_random_traffic(input int phases, input int per_phase);
      logic [mpr_pkg::POLICY_W-1:0] pol;
      logic [mpr_pkg::RATE_W-1:0] cap;
      int pick;
      int size_limit;
      int pressure_at;
      logic [mpr_pkg::BYTES_W-1:0] size;
      for (int p = 0; p < phases; p++) begin
         pick = $urandom_range(0, 19);
         pol = (pick < 6) ? mpr_pkg::POL_TOKEN : (pick < 11) ? mpr_pkg::POL_LEAKY :
               (pick < 19) ? mpr_pkg::POL_WINDOW : POL_UNUSED;
         cap = pick_register_value();
         csr_write(mpr_pkg::CSR_RATE, pick_register_value());
         if ($urandom_range(0, 1) == 0) begin
            csr_write(mpr_pkg::CSR_CAPACITY, cap);
            csr_write(mpr_pkg::CSR_POLICY, pol);
         end else begin
            csr_write(mpr_pkg::CSR_POLICY, pol);
            csr_write(mpr_pkg::CSR_CAPACITY, cap);
         end
         send_gaps = ($urandom_range(0, 3) != 0);
         recv_gaps = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0)
            now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 2000);
         pressure_at = $urandom_range(0, per_phase - 1);
         for (int i = 0; i < per_phase; i++) begin
            if (i == pressure_at)
               drain_results();
            pick = $urandom_range(0, 39);
            if (pick == 0)
               now_cursor = $urandom;
            else if (pick == 1)
               now_cursor += $urandom_range(995, 1005);
            else
               now_cursor += $urandom_range(0, 25);
            // Sizes mostly track the rate so that windows fill deep histories.
            pick = $urandom_range(0, 9);
            size_limit = (pick < 4) ? (lim_rate >> 6) : (lim_rate >> 3);
            if (size_limit > 65535)
               size_limit = 65535;
            if (size_limit < 1)
               size_limit = 1;
            if (pick == 0)
               size = 16'($urandom);
            else if (pick == 1)
               size = '0;
            else
               size = 16'($urandom_range(1, size_limit));
            send_word(($urandom_range(0, 4) == 0) ? mpr_pkg::MODE_TICK : mpr_pkg::MODE_OFFER,
                      size, now_cursor);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      now_cursor = $urandom;
      test_token_bucket();
      test_leaky_bucket();
      test_sliding_window();
      test_unused_policy();
      test_capacity_clamp();
      test_full_history();
      test_random_traffic(12, 48);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d packet offers and %0d refill ticks under all policy codes.",
               offers_seen, ticks_seen);
      $display("%0d results checked, %0d bursts, %0d window evictions, %0d full-history drops.",
               results_checked, bursts_seen, evictions, history_full_drops);
      if (errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/mpr_pkg.sv
rtl/core/mpr_ctrl.sv
rtl/core/mpr_dpath.sv
rtl/core/multi_policy_rate_limiter.sv
tb/tb_top.sv
